@@ hdl/adsr_table_envelope_generator_macros.svh @@
// assertion macros shared by the envelope generator checkers
// no dependencies; included by files that hold concurrent assertions
`ifndef ADSR_TABLE_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_TABLE_ENVELOPE_GENERATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ADSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked from the cycle after the antecedent
`define ADSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/adsr_pkg.sv @@
// shared types, constants and envelope rom contents for the adsr envelope generator
// no dependencies; imported by the interfaces, the top level and the checker
package adsr_pkg;

    // sizes and fixed-point formats
    localparam int TABLE_ENTRIES_DEF = 512;
    localparam int ROM_ENTRIES       = 512;
    localparam int ROM_AW            = 9;
    localparam int RISE_END          = 127;
    localparam int FALL_START        = 385;
    localparam int FRAC_W            = 16;
    localparam int RATE_W            = 23;
    localparam int SPEED_W           = 16;
    localparam int GAIN_W            = 17;
    localparam int LEVEL_W           = 17;
    localparam int PADDR_W           = 5;
    localparam int PDATA_W           = 32;

    localparam logic [LEVEL_W-1:0] UNITY     = 17'd65536;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 16'd256;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'd32768;

    // register map, word index into the apb space
    typedef enum logic [2:0] {
        REG_INV_DUR_ATTACK  = 3'd0,
        REG_INV_DUR_DECAY   = 3'd1,
        REG_INV_DUR_SUSTAIN = 3'd2,
        REG_INV_DUR_RELEASE = 3'd3,
        REG_PEAK_GAIN       = 3'd4,
        REG_SUSTAIN_GAIN    = 3'd5
    } adsr_reg_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_INTERP,
        ST_GAIN
    } adsr_state_t;

    // envelope segments
    typedef enum logic [1:0] {
        Q_ATTACK,
        Q_DECAY,
        Q_SUSTAIN,
        Q_RELEASE
    } adsr_quarter_t;

    // rising segment of the envelope rom
    localparam logic [15:0] RISE_ROM [RISE_END] = '{
        16'd0, 16'd80, 16'd161, 16'd244, 16'd330, 16'd417, 16'd507, 16'd599,
        16'd693, 16'd789, 16'd888, 16'd989, 16'd1092, 16'd1198, 16'd1307,
        16'd1418, 16'd1532, 16'd1649, 16'd1768, 16'd1890, 16'd2016, 16'd2144,
        16'd2276, 16'd2411, 16'd2548, 16'd2690, 16'd2835, 16'd2983, 16'd3135,
        16'd3290, 16'd3450, 16'd3613, 16'd3780, 16'd3951, 16'd4127, 16'd4306,
        16'd4490, 16'd4679, 16'd4872, 16'd5069, 16'd5272, 16'd5479, 16'd5692,
        16'd5909, 16'd6132, 16'd6360, 16'd6594, 16'd6834, 16'd7079, 16'd7330,
        16'd7588, 16'd7851, 16'd8121, 16'd8398, 16'd8681, 16'd8971, 16'd9268,
        16'd9573, 16'd9884, 16'd10204, 16'd10531, 16'd10866, 16'd11209,
        16'd11560, 16'd11920, 16'd12289, 16'd12667, 16'd13054, 16'd13450,
        16'd13856, 16'd14271, 16'd14697, 16'd15133, 16'd15580, 16'd16037,
        16'd16506, 16'd16986, 16'd17478, 16'd17981, 16'd18497, 16'd19025,
        16'd19566, 16'd20121, 16'd20688, 16'd21270, 16'd21865, 16'd22475,
        16'd23100, 16'd23740, 16'd24395, 16'd25067, 16'd25755, 16'd26459,
        16'd27180, 16'd27919, 16'd28676, 16'd29451, 16'd30246, 16'd31059,
        16'd31892, 16'd32745, 16'd33619, 16'd34514, 16'd35431, 16'd36370,
        16'd37332, 16'd38318, 16'd39327, 16'd40360, 16'd41419, 16'd42504,
        16'd43614, 16'd44752, 16'd45917, 16'd47111, 16'd48333, 16'd49586,
        16'd50868, 16'd52182, 16'd53527, 16'd54906, 16'd56317, 16'd57763,
        16'd59244, 16'd60761, 16'd62315, 16'd63906
    };

    // falling segment of the envelope rom
    localparam logic [15:0] FALL_ROM [ROM_ENTRIES - FALL_START] = '{
        16'd61437, 16'd58068, 16'd55208, 16'd52724, 16'd50527, 16'd48558,
        16'd46775, 16'd45145, 16'd43644, 16'd42253, 16'd40957, 16'd39744,
        16'd38604, 16'd37528, 16'd36510, 16'd35544, 16'd34625, 16'd33748,
        16'd32910, 16'd32108, 16'd31338, 16'd30598, 16'd29886, 16'd29199,
        16'd28537, 16'd27897, 16'd27278, 16'd26678, 16'd26097, 16'd25533,
        16'd24985, 16'd24453, 16'd23935, 16'd23431, 16'd22940, 16'd22462,
        16'd21995, 16'd21539, 16'd21094, 16'd20659, 16'd20234, 16'd19819,
        16'd19412, 16'd19014, 16'd18624, 16'd18241, 16'd17867, 16'd17499,
        16'd17139, 16'd16785, 16'd16438, 16'd16097, 16'd15762, 16'd15433,
        16'd15109, 16'd14791, 16'd14478, 16'd14171, 16'd13868, 16'd13569,
        16'd13276, 16'd12987, 16'd12702, 16'd12422, 16'd12145, 16'd11873,
        16'd11604, 16'd11339, 16'd11078, 16'd10821, 16'd10566, 16'd10316,
        16'd10068, 16'd9824, 16'd9582, 16'd9344, 16'd9109, 16'd8876, 16'd8647,
        16'd8420, 16'd8196, 16'd7974, 16'd7755, 16'd7539, 16'd7325, 16'd7113,
        16'd6904, 16'd6697, 16'd6492, 16'd6289, 16'd6089, 16'd5890, 16'd5694,
        16'd5500, 16'd5307, 16'd5117, 16'd4929, 16'd4742, 16'd4557, 16'd4374,
        16'd4193, 16'd4013, 16'd3835, 16'd3659, 16'd3484, 16'd3311, 16'd3140,
        16'd2970, 16'd2801, 16'd2634, 16'd2469, 16'd2305, 16'd2142, 16'd1981,
        16'd1821, 16'd1662, 16'd1505, 16'd1349, 16'd1194, 16'd1041, 16'd889,
        16'd738, 16'd588, 16'd439, 16'd292, 16'd145, 16'd0
    };

    // envelope rom: rise, flat top, fall
    function automatic logic [LEVEL_W-1:0] rom_value(input logic [ROM_AW-1:0] e);
        logic [6:0] k;
        k = 7'(e - ROM_AW'(FALL_START));
        priority if (e < ROM_AW'(RISE_END))
            rom_value = {1'b0, RISE_ROM[e[6:0]]};
        else if (e < ROM_AW'(FALL_START))
            rom_value = UNITY;
        else
            rom_value = {1'b0, FALL_ROM[k]};
    endfunction

    // speed factor limited to its legal range
    function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] v);
        priority if (v < SPEED_MIN)
            clamp_speed = SPEED_MIN;
        else if (v > SPEED_MAX)
            clamp_speed = SPEED_MAX;
        else
            clamp_speed = v;
    endfunction

endpackage

@@ hdl/adsr_if.sv @@
// valid/ready channel interfaces for tick requests and envelope results
// depends on adsr_pkg for the payload widths
interface adsr_tick_if import adsr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate;

    modport source (output valid, output rate, input ready);
    modport sink   (input valid, input rate, output ready);
endinterface

interface adsr_level_if import adsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

@@ hdl/adsr_table_envelope_generator.sv @@
// adsr envelope generator: table phase over an envelope rom, apb register port
// depends on adsr_pkg and on the adsr_tick_if / adsr_level_if interfaces
// sequence: a tick request is accepted in idle, then the phase update with rom read,
//   the interpolation multiply and the gain multiply follow; one request at a time,
//   the next is taken only after the result is loaded, later while it is not taken
// reset: rst_n is asynchronous, clears phase and sequencer, loads register defaults
module adsr_table_envelope_generator import adsr_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    adsr_tick_if.sink          tick,
    adsr_level_if.source       envelope,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IdxW    = $clog2(TABLE_ENTRIES);
    localparam int PhaseW  = IdxW + FRAC_W;
    localparam int Quarter = TABLE_ENTRIES / 4;
    localparam int ProdW   = RATE_W + SPEED_W;
    localparam int StepW   = ProdW - 8;

    localparam logic [PhaseW:0]   SPAN     = (PhaseW+1)'(TABLE_ENTRIES) << FRAC_W;
    localparam logic [StepW-1:0]  STEP_MAX = StepW'(SPAN - 1'b1);
    localparam logic [PhaseW:0]   LIM1     = (PhaseW+1)'(Quarter) << FRAC_W;
    localparam logic [PhaseW:0]   LIM2     = (PhaseW+1)'(2 * Quarter) << FRAC_W;
    localparam logic [PhaseW:0]   LIM3     = (PhaseW+1)'(3 * Quarter) << FRAC_W;
    localparam logic [IdxW-1:0]   QB1      = IdxW'(Quarter);
    localparam logic [IdxW-1:0]   QB2      = IdxW'(2 * Quarter);
    localparam logic [IdxW-1:0]   QB3      = IdxW'(3 * Quarter);
    localparam logic [IdxW-1:0]   LAST_IDX = IdxW'(TABLE_ENTRIES - 1);

    // configuration registers
    logic [SPEED_W-1:0] inv_dur_attack_reg;
    logic [SPEED_W-1:0] inv_dur_decay_reg;
    logic [SPEED_W-1:0] inv_dur_sustain_reg;
    logic [SPEED_W-1:0] inv_dur_release_reg;
    logic [GAIN_W-1:0]  peak_gain_reg;
    logic [GAIN_W-1:0]  sustain_gain_reg;

    // datapath and control
    adsr_state_t        state_reg, state_next;
    adsr_quarter_t      q_reg, q_next;
    logic [PhaseW-1:0]  phase_reg, phase_next;
    logic [ProdW-1:0]   prod_reg, prod_next;
    logic [LEVEL_W-1:0] a_reg, b_reg, v_reg, v_next;
    logic [FRAC_W-1:0]  frac_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               out_valid_reg;

    logic               accept;
    logic               load_out;
    logic               cfg_write;
    adsr_reg_t          cfg_sel;
    logic [IdxW-1:0]    cur_idx;
    logic [SPEED_W-1:0] speed_sel;
    logic [StepW-1:0]   step_raw, step_sat;
    logic [PhaseW:0]    sum, limit, phase_fix;
    logic [IdxW-1:0]    new_idx, nxt_idx;
    logic signed [17:0] diff;
    logic signed [34:0] interp_prod, interp_rnd;
    logic signed [18:0] interp_sum;
    logic [GAIN_W-1:0]  gain_sel, gain_use;
    logic [33:0]        gain_prod;

    // envelope rom resampled to the table size
    logic [LEVEL_W-1:0] env_tab [TABLE_ENTRIES];

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_rom
        localparam int RomIdx = (gi * ROM_ENTRIES) / TABLE_ENTRIES;
        assign env_tab[gi] = rom_value(ROM_AW'(RomIdx));
    end

    // apb register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = adsr_reg_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_dur_attack_reg  <= 16'd256;
            inv_dur_decay_reg   <= 16'd256;
            inv_dur_sustain_reg <= 16'd256;
            inv_dur_release_reg <= 16'd256;
            peak_gain_reg       <= UNITY;
            sustain_gain_reg    <= UNITY;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_INV_DUR_ATTACK:  inv_dur_attack_reg  <= pwdata[SPEED_W-1:0];
                REG_INV_DUR_DECAY:   inv_dur_decay_reg   <= pwdata[SPEED_W-1:0];
                REG_INV_DUR_SUSTAIN: inv_dur_sustain_reg <= pwdata[SPEED_W-1:0];
                REG_INV_DUR_RELEASE: inv_dur_release_reg <= pwdata[SPEED_W-1:0];
                REG_PEAK_GAIN:       peak_gain_reg       <= pwdata[GAIN_W-1:0];
                REG_SUSTAIN_GAIN:    sustain_gain_reg    <= pwdata[GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_sel)
            REG_INV_DUR_ATTACK:  prdata = PDATA_W'(inv_dur_attack_reg);
            REG_INV_DUR_DECAY:   prdata = PDATA_W'(inv_dur_decay_reg);
            REG_INV_DUR_SUSTAIN: prdata = PDATA_W'(inv_dur_sustain_reg);
            REG_INV_DUR_RELEASE: prdata = PDATA_W'(inv_dur_release_reg);
            REG_PEAK_GAIN:       prdata = PDATA_W'(peak_gain_reg);
            REG_SUSTAIN_GAIN:    prdata = PDATA_W'(sustain_gain_reg);
            default:             prdata = '0;
        endcase
    end

    // segment of the current phase and its speed factor
    assign cur_idx = phase_reg[PhaseW-1:FRAC_W];

    always_comb
    begin
        priority if (cur_idx >= QB3)
            q_next = Q_RELEASE;
        else if (cur_idx >= QB2)
            q_next = Q_SUSTAIN;
        else if (cur_idx >= QB1)
            q_next = Q_DECAY;
        else
            q_next = Q_ATTACK;

        unique case (q_next)
            Q_ATTACK:  speed_sel = clamp_speed(inv_dur_attack_reg);
            Q_DECAY:   speed_sel = clamp_speed(inv_dur_decay_reg);
            Q_SUSTAIN: speed_sel = clamp_speed(inv_dur_sustain_reg);
            Q_RELEASE: speed_sel = clamp_speed(inv_dur_release_reg);
            default:   speed_sel = SPEED_MIN;
        endcase
    end

    // rate times speed, taken on the accept cycle
    assign accept    = tick.valid && tick.ready;
    assign prod_next = ProdW'(tick.rate) * ProdW'(speed_sel);

    // saturated step, advance, clamp at segment end or wrap in release
    assign step_raw = prod_reg[ProdW-1:8];
    assign step_sat = (step_raw > STEP_MAX) ? STEP_MAX : step_raw;
    assign sum      = {1'b0, phase_reg} + (PhaseW+1)'(step_sat);

    always_comb
    begin
        unique case (q_reg)
            Q_ATTACK:  limit = LIM1;
            Q_DECAY:   limit = LIM2;
            Q_SUSTAIN: limit = LIM3;
            Q_RELEASE: limit = SPAN;
            default:   limit = SPAN;
        endcase

        if (q_reg == Q_RELEASE)
            phase_fix = (sum >= SPAN) ? (sum - SPAN) : sum;
        else
            phase_fix = (sum > limit) ? limit : sum;
    end

    assign phase_next = phase_fix[PhaseW-1:0];
    assign new_idx    = phase_next[PhaseW-1:FRAC_W];
    assign nxt_idx    = (new_idx == LAST_IDX) ? '0 : (new_idx + 1'b1);

    // linear interpolation: a + round((b - a) * frac)
    assign diff        = $signed({1'b0, b_reg}) - $signed({1'b0, a_reg});
    assign interp_prod = diff * $signed({1'b0, frac_reg});
    assign interp_rnd  = interp_prod + 35'sd32768;
    assign interp_sum  = $signed({2'b00, a_reg}) + $signed(interp_rnd[34:16]);
    assign v_next      = interp_sum[LEVEL_W-1:0];

    // gain, clamped to one, rounded half up
    assign gain_sel   = (q_reg == Q_SUSTAIN) ? sustain_gain_reg : peak_gain_reg;
    assign gain_use   = (gain_sel > UNITY) ? UNITY : gain_sel;
    assign gain_prod  = 34'(v_reg) * 34'(gain_use) + 34'd32768;
    assign level_next = gain_prod[32:16];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        tick.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                tick.ready = 1'b1;
                if (tick.valid)
                    state_next = ST_ADV;
            end
            ST_ADV:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_GAIN;
            ST_GAIN:
            begin
                if (!out_valid_reg || envelope.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ADV)
                phase_reg <= phase_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (envelope.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers and synchronous rom reads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= prod_next;
            q_reg    <= q_next;
        end
        if (state_reg == ST_ADV)
        begin
            a_reg    <= env_tab[new_idx];
            b_reg    <= env_tab[nxt_idx];
            frac_reg <= phase_next[FRAC_W-1:0];
        end
        if (state_reg == ST_INTERP)
            v_reg <= v_next;
        if (load_out)
            level_reg <= level_next;
    end

    assign envelope.valid = out_valid_reg;
    assign envelope.level = level_reg;

endmodule

@@ hdl/adsr_checker.sv @@
// port-level checker for the adsr envelope generator, bound to the top level
// depends on adsr_pkg and adsr_table_envelope_generator_macros.svh
`include "adsr_table_envelope_generator_macros.svh"

module adsr_checker import adsr_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               tick_valid,
    input logic               tick_ready,
    input logic               env_valid,
    input logic               env_ready,
    input logic [LEVEL_W-1:0] env_level
);

    logic tick_acc;

    assign tick_acc = tick_valid && tick_ready;

    // a level never exceeds unity gain
    `ADSR_ASSERT_SAME(a_level_range, clk, rst_n, env_valid, env_level <= UNITY, "level above one")

    // one request at a time: no new request taken while the previous one is in progress
    `ADSR_ASSERT_NEXT(a_busy_after_req, clk, rst_n, tick_acc, !tick_ready ##1 !tick_ready ##1 !tick_ready, "request taken while busy")

    // a result cannot appear while a taken request is still in its phase update or interpolation
    `ADSR_ASSERT_NEXT(a_no_early_result, clk, rst_n, tick_acc, !$rose(env_valid) ##1 !$rose(env_valid), "result too early")

    // a stalled result holds
    `ADSR_ASSERT_NEXT(a_hold_stalled, clk, rst_n, env_valid && !env_ready, env_valid && $stable(env_level), "stalled result changed")

endmodule

bind adsr_table_envelope_generator adsr_checker u_adsr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .env_valid  (envelope.valid),
    .env_ready  (envelope.ready),
    .env_level  (envelope.level)
);
